// ===== rtl/core/htwd_pkg.sv =====
// shared constants and types for the huffman tree walk decoder
// used by the top level and by the port checker; no dependencies
`default_nettype none

package htwd_pkg;

    localparam int MAX_NODES  = 256;
    localparam int NODE_W     = $clog2(MAX_NODES);
    localparam int COUNT_W    = NODE_W + 1;
    localparam int CHILD_W    = 10;
    localparam int ENTRY_W    = 2 * CHILD_W;
    localparam int SYM_W      = 8;
    localparam int BYTE_W     = 8;
    localparam int BIT_CNT_W  = $clog2(BYTE_W);
    localparam int TOKEN_W    = CHILD_W - 1;

    localparam logic [TOKEN_W-1:0] END_TOKEN = TOKEN_W'(256);
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_NODES);

    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 8;
    localparam int M_TUSER_W  = 2;

    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam logic REG_NODE_COUNT = 1'b0;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             is_end;
        logic             bad_tree;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/htwd_ram.sv =====
// generic simple dual port ram, one write port and one read port
// read data is registered and holds while no read is issued; no dependencies
`default_nettype none

module htwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/huffman_tree_walk_decoder.sv =====
// huffman tree walk decoder: a load word writes one node and leaves it idle
// a decode word walks its eight bits at one table read per cycle while the
// result side does not stall, then a flush state sends the held result as last
// a stall on the result side holds the walk; s_tready is high only when idle
// synchronous active low reset clears the walk, node count and result valid
// the node table has no reset and is defined only where loaded
`default_nettype none

module huffman_tree_walk_decoder
    import htwd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // node_index, left_child, right_child, data_byte
    input  wire logic                 s_tuser,   // func
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,   // symbol
    output logic      [M_TUSER_W-1:0] m_tuser,   // is_end, bad_tree
    output logic                      m_tlast,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [PADDR_W-1:0]   paddr,
    input  wire logic [PDATA_W-1:0]   pwdata,
    output logic      [PDATA_W-1:0]   prdata,
    output logic                      pready
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [NODE_W-1:0]    cur_node_reg, cur_node_next;
    logic [COUNT_W-1:0]   node_count_reg, node_count_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [BYTE_W-1:0]    data_reg, data_next;
    result_t              pend_reg, pend_next;
    logic                 pend_valid_reg, pend_valid_next;
    result_t              out_reg, out_next;
    logic                 out_last_reg, out_last_next;
    logic                 m_valid_reg, m_valid_next;

    logic [NODE_W-1:0]    in_node_index;
    logic [CHILD_W-1:0]   in_left, in_right;
    logic [BYTE_W-1:0]    in_data_byte;
    logic                 s_accept, cfg_write;
    logic [COUNT_W-1:0]   wr_count;

    logic                 ram_we, ram_re;
    logic [NODE_W-1:0]    ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;

    logic [CHILD_W-1:0]   child;
    logic [TOKEN_W-1:0]   token;
    logic                 emit, out_free, advance;
    result_t              bit_res;
    logic [NODE_W-1:0]    walk_node;

    assign in_node_index = s_tdata[NODE_W-1:0];
    assign in_left       = s_tdata[8 +: CHILD_W];
    assign in_right      = s_tdata[18 +: CHILD_W];
    assign in_data_byte  = s_tdata[28 +: BYTE_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_NODE_COUNT);
    assign wr_count  = (pwdata[COUNT_W-1:0] > COUNT_MAX) ? COUNT_MAX : pwdata[COUNT_W-1:0];
    assign prdata    = (paddr[2] == REG_NODE_COUNT) ?
                       {{(PDATA_W-COUNT_W){1'b0}}, node_count_reg} : '0;

    assign ram_we = s_accept && (s_tuser == FUNC_LOAD);

    htwd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_NODES)
    ) u_node_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (in_node_index),
        .wdata ({in_right, in_left}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // one tree step for the current bit
    always_comb begin
        child     = data_reg[0] ? ram_rdata[ENTRY_W-1:CHILD_W] : ram_rdata[CHILD_W-1:0];
        token     = ~child[TOKEN_W-1:0];
        bit_res   = '0;
        emit      = 1'b0;
        walk_node = '0;
        if (node_count_reg == '0) begin
            emit           = 1'b1;
            bit_res.is_end = 1'b1;
        end else if (!child[CHILD_W-1]) begin
            if (COUNT_W'(child[TOKEN_W-1:0]) >= node_count_reg) begin
                emit             = 1'b1;
                bit_res.bad_tree = 1'b1;
            end else begin
                walk_node = child[NODE_W-1:0];
            end
        end else begin
            emit = 1'b1;
            if (token == END_TOKEN) begin
                bit_res.is_end = 1'b1;
            end else if (token > END_TOKEN) begin
                bit_res.bad_tree = 1'b1;
            end else begin
                bit_res.symbol = token[SYM_W-1:0];
            end
        end
    end

    assign out_free = !m_valid_reg || m_tready;
    assign advance  = !(emit && pend_valid_reg && !out_free);

    always_comb begin
        state_next      = state_reg;
        cur_node_next   = cur_node_reg;
        node_count_next = node_count_reg;
        bit_cnt_next    = bit_cnt_reg;
        data_next       = data_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        ram_re          = 1'b0;
        ram_raddr       = cur_node_reg;

        if (cfg_write) begin
            node_count_next = wr_count;
            cur_node_next   = '0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept && (s_tuser == FUNC_DECODE)) begin
                    ram_re       = 1'b1;
                    ram_raddr    = cur_node_reg;
                    data_next    = in_data_byte;
                    bit_cnt_next = '0;
                    state_next   = ST_RUN;
                end
            end
            ST_RUN: begin
                if (advance) begin
                    if (emit) begin
                        if (pend_valid_reg) begin
                            out_next      = pend_reg;
                            out_last_next = 1'b0;
                            m_valid_next  = 1'b1;
                        end
                        pend_next       = bit_res;
                        pend_valid_next = 1'b1;
                    end
                    cur_node_next = walk_node;
                    data_next     = {1'b0, data_reg[BYTE_W-1:1]};
                    bit_cnt_next  = bit_cnt_reg + 1'b1;
                    if (bit_cnt_reg == BIT_CNT_W'(BYTE_W - 1)) begin
                        state_next = ST_FLUSH;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = walk_node;
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_next        = pend_reg;
                    out_last_next   = 1'b1;
                    m_valid_next    = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cur_node_reg   <= '0;
            node_count_reg <= '0;
            bit_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cur_node_reg   <= cur_node_next;
            node_count_reg <= node_count_next;
            bit_cnt_reg    <= bit_cnt_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg     <= data_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg.symbol;
    assign m_tuser  = {out_reg.bad_tree, out_reg.is_end};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/htwd_checker.sv =====
// port level checks for the huffman tree walk decoder, bound to the top level
// depends on htwd_pkg
`default_nettype none

module htwd_checker
    import htwd_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic [M_TUSER_W-1:0] m_tuser,
    input wire logic                 m_tlast
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result word changed while stalled");

    // end and error never flagged together
    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("end and bad_tree both set");

    // flagged results carry a zero symbol
    a_flag_sym: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[0] || m_tuser[1]) |-> m_tdata == '0)
        else $error("nonzero symbol on end or error word");

    // no result word right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind huffman_tree_walk_decoder htwd_checker u_htwd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
